FILE: sv/frt_pkg.sv
package frt_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int OUT_SLOT_W = 4;

  typedef enum logic [1:0] {
    K_INSERT = 2'd0,
    K_LOOKUP = 2'd1,
    K_REMOVE = 2'd2,
    K_DUMP   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STS_DONE    = 3'd0,
    STS_PRESENT = 3'd1,
    STS_FULL    = 3'd2,
    STS_MISS    = 3'd3,
    STS_EMPTY   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [31:0] key;
    logic [7:0]  age;
    logic [63:0] name_low;
    logic [63:0] name_mid;
    logic [31:0] name_high;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
  } ram_ctl_t;

  typedef struct packed {
    logic                  valid;
    status_t               status;
    logic [OUT_SLOT_W-1:0] slot;
    rec_t                  rec;
    logic                  last;
  } res_t;

endpackage

FILE: sv/frt_ram.sv
module frt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/frt_scan.sv
module frt_scan (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  frt_pkg::kind_t   req_kind,
  input  logic [31:0]      req_key,
  input  frt_pkg::rec_t    rd_data,
  output logic             busy,
  output frt_pkg::ram_ctl_t ctl,
  output frt_pkg::res_t    res
);

  import frt_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             hit_v_r, hit_v_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  rec_t             hit_rec_r, hit_rec_nxt;
  logic             free_v_r, free_v_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [SLOTS-1:0] used_r, used_nxt;
  logic             used_here;
  logic             match;

  assign busy = (state_r != S_IDLE);
  assign used_here = used_r[cmp_idx_r];
  assign match = used_here && (rd_data.key == req_key);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      cmp_v_r  <= 1'b0;
      hit_v_r  <= 1'b0;
      free_v_r <= 1'b0;
      used_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      cmp_v_r  <= cmp_v_nxt;
      hit_v_r  <= hit_v_nxt;
      free_v_r <= free_v_nxt;
      used_r   <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r  <= cmp_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_rec_r  <= hit_rec_nxt;
    free_idx_r <= free_idx_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmp_v_nxt    = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    hit_v_nxt    = hit_v_r;
    hit_idx_nxt  = hit_idx_r;
    hit_rec_nxt  = hit_rec_r;
    free_v_nxt   = free_v_r;
    free_idx_nxt = free_idx_r;
    used_nxt     = used_r;
    ctl          = '0;
    res          = '0;
    res.status   = STS_DONE;

    // compare stage, one slot per cycle behind the read
    if (cmp_v_r) begin
      if (match && !hit_v_r) begin
        hit_v_nxt   = 1'b1;
        hit_idx_nxt = cmp_idx_r;
        hit_rec_nxt = rd_data;
      end
      if (!used_here && !free_v_r) begin
        free_v_nxt   = 1'b1;
        free_idx_nxt = cmp_idx_r;
      end
      if (req_kind == K_DUMP) begin
        res.valid  = 1'b1;
        res.status = used_here ? STS_DONE : STS_EMPTY;
        res.slot   = OUT_SLOT_W'(cmp_idx_r);
        res.rec    = used_here ? rd_data : '0;
        res.last   = (cmp_idx_r == IDX_W'(SLOTS - 1));
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cnt_nxt    = '0;
          hit_v_nxt  = 1'b0;
          free_v_nxt = 1'b0;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_r != CNT_W'(SLOTS)) begin
          ctl.rd_en   = 1'b1;
          ctl.rd_addr = IDX_W'(cnt_r);
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = IDX_W'(cnt_r);
          cnt_nxt     = cnt_r + CNT_W'(1);
        end else begin
          state_nxt = (req_kind == K_DUMP) ? S_IDLE : S_RESP;
        end
      end
      S_RESP: begin
        res.valid = 1'b1;
        res.last  = 1'b1;
        unique case (req_kind)
          K_INSERT: begin
            if (hit_v_r) begin
              res.status = STS_PRESENT;
              res.slot   = OUT_SLOT_W'(hit_idx_r);
            end else if (free_v_r) begin
              res.status           = STS_DONE;
              res.slot             = OUT_SLOT_W'(free_idx_r);
              ctl.wr_en            = 1'b1;
              ctl.wr_addr          = free_idx_r;
              used_nxt[free_idx_r] = 1'b1;
            end else begin
              res.status = STS_FULL;
            end
          end
          K_LOOKUP: begin
            if (hit_v_r) begin
              res.status = STS_DONE;
              res.slot   = OUT_SLOT_W'(hit_idx_r);
              res.rec    = hit_rec_r;
            end else begin
              res.status = STS_MISS;
            end
          end
          K_REMOVE: begin
            if (hit_v_r) begin
              res.status          = STS_DONE;
              res.slot            = OUT_SLOT_W'(hit_idx_r);
              used_nxt[hit_idx_r] = 1'b0;
            end else begin
              res.status = STS_MISS;
            end
          end
          K_DUMP: begin
            res.valid = 1'b0;
            res.last  = 1'b0;
          end
          default: begin
            res.valid = 1'b0;
          end
        endcase
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
    start && state_r == S_IDLE |=> state_r == S_SCAN)
    else $error("accepted item did not start a scan");

  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wr_en |-> !used_r[ctl.wr_addr])
    else $error("insert overwrites a live slot");

  a_write_marks: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wr_en |=> used_r[$past(ctl.wr_addr)])
    else $error("inserted slot not marked used");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.last |=> state_r == S_IDLE)
    else $error("final result not followed by idle");

  a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> state_r != S_IDLE)
    else $error("result while idle");
`endif

endmodule

FILE: sv/fixed_slot_record_table_top.sv
// Fixed-slot record table with linear key scan.
// Input: a request item is taken at a rising edge with start high and busy
// low. in_kind selects insert, lookup, remove or dump; in_key is the key;
// in_age and in_name_* are stored by insert.
// Output: each result is shown for exactly one cycle with out_valid high;
// out_last marks the final result of a request. The receiver cannot stall.
// Flow with SLOTS slots: every request reads the record RAM one slot per
// cycle through a single key comparator, then lets the last compare drain.
// Insert, lookup and remove give one result after the scan, from the
// S_RESP state through the output register; dump gives SLOTS results, one
// per cycle, from the compare stage through the output register. The next
// item is accepted only once busy is low again, after the last one is done.
// Insert writes the record RAM and the used mark in its last busy cycle.
// Reset (rst_n low, synchronous) marks every slot free and returns to idle;
// record contents are not cleared, and only those of used slots are ever output.
module fixed_slot_record_table_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_key,
  input  logic [7:0]         in_age,
  input  logic [63:0]        in_name_low,
  input  logic [63:0]        in_name_mid,
  input  logic [31:0]        in_name_high,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [3:0]         out_slot,
  output logic signed [31:0] out_rec_key,
  output logic [7:0]         out_rec_age,
  output logic [63:0]        out_rec_name_low,
  output logic [63:0]        out_rec_name_mid,
  output logic [31:0]        out_rec_name_high,
  output logic               out_last
);

  import frt_pkg::*;

  kind_t    kind_r;
  rec_t     req_r;
  logic     accept;
  ram_ctl_t ctl;
  rec_t     rd_data;
  logic [REC_W-1:0] rd_bits;
  res_t     res;
  logic     out_valid_r;
  res_t     out_r;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r          <= kind_t'(in_kind);
      req_r.key       <= in_key;
      req_r.age       <= in_age;
      req_r.name_low  <= in_name_low;
      req_r.name_mid  <= in_name_mid;
      req_r.name_high <= in_name_high;
    end
  end

  frt_ram #(
    .WIDTH (REC_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ctl.wr_en),
    .wr_addr (ctl.wr_addr),
    .wr_data (req_r),
    .rd_en   (ctl.rd_en),
    .rd_addr (ctl.rd_addr),
    .rd_data (rd_bits)
  );

  assign rd_data = rec_t'(rd_bits);

  frt_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_kind (kind_r),
    .req_key  (req_r.key),
    .rd_data  (rd_data),
    .busy     (busy),
    .ctl      (ctl),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= res;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_slot          = out_r.slot;
  assign out_rec_key       = out_r.rec.key;
  assign out_rec_age       = out_r.rec.age;
  assign out_rec_name_low  = out_r.rec.name_low;
  assign out_rec_name_mid  = out_r.rec.name_mid;
  assign out_rec_name_high = out_r.rec.name_high;
  assign out_last          = out_r.last;

endmodule

FILE: tb/record_table_checker.sv
module record_table_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_key,
  input  logic [7:0]         in_age,
  input  logic [63:0]        in_name_low,
  input  logic [63:0]        in_name_mid,
  input  logic [31:0]        in_name_high,
  input  logic               out_valid,
  input  logic [2:0]         out_status,
  input  logic [3:0]         out_slot,
  input  logic signed [31:0] out_rec_key,
  input  logic [7:0]         out_rec_age,
  input  logic [63:0]        out_rec_name_low,
  input  logic [63:0]        out_rec_name_mid,
  input  logic [31:0]        out_rec_name_high,
  input  logic               out_last,
  output int                 mismatches,
  output int                 pending
);

  import frt_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [3:0]  slot;
    rec_t        rec;
    logic        last;
  } table_result_t;

  logic          used_tbl [SLOTS];
  rec_t          rec_tbl [SLOTS];
  table_result_t results_due [$];
  int            fail_count = 0;
  int            due_count = 0;

  assign mismatches = fail_count;
  assign pending    = due_count;

  initial begin
    foreach (used_tbl[i]) used_tbl[i] = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic int find_live(input logic [31:0] key);
    int hit;
    hit = -1;
    for (int i = SLOTS - 1; i >= 0; i--)
      if (used_tbl[i] && rec_tbl[i].key == key) hit = i;
    return hit;
  endfunction

  task automatic apply_request(input kind_t kind, input logic [31:0] key,
                               input logic [7:0] age, input logic [63:0] nl,
                               input logic [63:0] nm, input logic [31:0] nh);
    table_result_t r;
    int            hit;
    int            free_slot;
    r = '0;
    r.last = 1'b1;
    hit = find_live(key);
    case (kind)
      K_INSERT: begin
        free_slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--)
          if (!used_tbl[i]) free_slot = i;
        if (hit >= 0) begin
          r.status = STS_PRESENT;
          r.slot   = hit[3:0];
        end else if (free_slot >= 0) begin
          used_tbl[free_slot] = 1'b1;
          rec_tbl[free_slot]  = '{key: key, age: age, name_low: nl,
                                  name_mid: nm, name_high: nh};
          r.status = STS_DONE;
          r.slot   = free_slot[3:0];
        end else begin
          r.status = STS_FULL;
        end
        results_due.push_back(r);
      end
      K_LOOKUP, K_REMOVE: begin
        if (hit >= 0) begin
          r.status = STS_DONE;
          r.slot   = hit[3:0];
          if (kind == K_LOOKUP) r.rec = rec_tbl[hit];
          else used_tbl[hit] = 1'b0;
        end else begin
          r.status = STS_MISS;
        end
        results_due.push_back(r);
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) begin
          r = '0;
          r.slot = i[3:0];
          r.last = (i == SLOTS - 1);
          if (used_tbl[i]) begin
            r.status = STS_DONE;
            r.rec    = rec_tbl[i];
          end else begin
            r.status = STS_EMPTY;
          end
          results_due.push_back(r);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (!rst_n) begin
      foreach (used_tbl[i]) used_tbl[i] = 1'b0;
      results_due.delete();
    end else begin
      if (out_valid) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing expected, slot", 64'(out_slot), '0);
        end else begin
          want = results_due.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", 64'(out_status), 64'(want.status));
          if (out_slot !== want.slot)
            report_mismatch("slot", 64'(out_slot), 64'(want.slot));
          if (out_rec_key !== want.rec.key)
            report_mismatch("rec_key", 64'($unsigned(out_rec_key)), 64'(want.rec.key));
          if (out_rec_age !== want.rec.age)
            report_mismatch("rec_age", 64'(out_rec_age), 64'(want.rec.age));
          if (out_rec_name_low !== want.rec.name_low)
            report_mismatch("rec_name_low", out_rec_name_low, want.rec.name_low);
          if (out_rec_name_mid !== want.rec.name_mid)
            report_mismatch("rec_name_mid", out_rec_name_mid, want.rec.name_mid);
          if (out_rec_name_high !== want.rec.name_high)
            report_mismatch("rec_name_high", 64'(out_rec_name_high),
                            64'(want.rec.name_high));
          if (out_last !== want.last)
            report_mismatch("last", 64'(out_last), 64'(want.last));
        end
      end
      if (start && !busy)
        apply_request(kind_t'(in_kind), in_key, in_age, in_name_low,
                      in_name_mid, in_name_high);
    end
    due_count = results_due.size();
  end

endmodule

FILE: tb/fixed_slot_record_table_top_tb.sv
module fixed_slot_record_table_top_tb;
  import frt_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_kind = '0;
  logic signed [31:0] in_key = '0;
  logic [7:0]         in_age = '0;
  logic [63:0]        in_name_low = '0;
  logic [63:0]        in_name_mid = '0;
  logic [31:0]        in_name_high = '0;
  logic               out_valid;
  logic [2:0]         out_status;
  logic [3:0]         out_slot;
  logic signed [31:0] out_rec_key;
  logic [7:0]         out_rec_age;
  logic [63:0]        out_rec_name_low;
  logic [63:0]        out_rec_name_mid;
  logic [31:0]        out_rec_name_high;
  logic               out_last;
  int                 mismatches;
  int                 pending;

  int                 burst_left = 4;
  logic [31:0]        key_pool [20];

  fixed_slot_record_table_top u_top (.*);

  record_table_checker u_checker (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  // hold: stop sending until every result owed has come back
  task automatic send_item(input kind_t k, input logic [31:0] key,
                           input logic [7:0] age, input logic [63:0] nl,
                           input logic [63:0] nm, input logic [31:0] nh,
                           input bit hold);
    in_kind      <= k;
    in_key       <= key;
    in_age       <= age;
    in_name_low  <= nl;
    in_name_mid  <= nm;
    in_name_high <= nh;
    start        <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    burst_left--;
    if (hold || burst_left <= 0) begin
      start <= 1'b0;
      if (hold) begin
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
  endtask

  initial begin
    int    roll;
    int    ins_pct;
    kind_t k;
    logic [31:0] key;

    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    key_pool[4] = 32'h0000_0001;
    for (int i = 5; i < 20; i++) key_pool[i] = $urandom;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: dump, misses
    send_item(K_DUMP, '0, '0, '0, '0, '0, 1'b0);
    send_item(K_LOOKUP, 32'h0, '0, '0, '0, '0, 1'b0);
    send_item(K_REMOVE, 32'h8000_0000, '0, '0, '0, '0, 1'b0);
    // key and field extremes, fill to full and beyond, then dump, lookup, remove, insert
    send_item(K_INSERT, 32'h8000_0000, 8'h00, '0, '0, '0, 1'b0);
    send_item(K_INSERT, 32'h7FFF_FFFF, 8'hFF, '1, '1, '1, 1'b0);
    send_item(K_INSERT, 32'h0, 8'h01, {$urandom, $urandom}, {$urandom, $urandom},
              $urandom, 1'b0);
    send_item(K_INSERT, 32'hFFFF_FFFF, 8'h80, 64'h0000_0000_006F_6C61,
              '0, '0, 1'b0);
    for (int i = 0; i < SLOTS - 4; i++)
      send_item(K_INSERT, 32'd100 + i, 8'($urandom), {$urandom, $urandom},
                {$urandom, $urandom}, $urandom, 1'b0);
    send_item(K_INSERT, 32'h1234, 8'h11, '1, '0, '1, 1'b0);
    send_item(K_INSERT, 32'h0, 8'h22, '0, '1, '0, 1'b0);
    send_item(K_DUMP, '0, '0, '0, '0, '0, 1'b0);
    send_item(K_LOOKUP, 32'h7FFF_FFFF, '0, '0, '0, '0, 1'b0);
    send_item(K_REMOVE, 32'h0, '0, '0, '0, '0, 1'b0);
    send_item(K_LOOKUP, 32'h0, '0, '0, '0, '0, 1'b0);
    send_item(K_INSERT, 32'hABCD, 8'h33, {$urandom, $urandom}, {$urandom, $urandom},
              $urandom, 1'b0);
    send_item(K_REMOVE, 32'h8000_0000, '0, '0, '0, '0, 1'b1);

    // alternate fill-heavy and drain-heavy stretches
    for (int n = 0; n < 400; n++) begin
      ins_pct = ((n / 60) % 2 == 1) ? 65 : 25;
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) k = K_INSERT;
      else if (roll < ins_pct + (95 - ins_pct) / 2) k = K_LOOKUP;
      else if (roll < 95) k = K_REMOVE;
      else k = K_DUMP;
      if ($urandom_range(0, 6) == 0) key = $urandom;
      else key = key_pool[$urandom_range(0, 19)];
      send_item(k, key, 8'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                $urandom, (n % 100 == 99));
    end

    repeat (SLOTS + 8) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
